[design/asid_first_free_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ASID allocator
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASID_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH
`define ASID_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on clk, off during rst.
`define AFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// Next-cycle implication, clocked on clk, off during rst.
`define AFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define AFA_ASSERT_IMP(lbl, ante, cons)
`define AFA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/afa_pkg.sv]
// ----------------------------------------------------------------------------
// ASID allocator package
// Sizes, codes and helper functions shared by the allocator and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afa_pkg;

  localparam int ID_COUNT     = 1024;
  localparam int ID_SHIFT     = 28;
  localparam int ENTRY_OFFSET = 12;
  localparam int TOTAL_SHIFT  = ID_SHIFT + ENTRY_OFFSET;
  localparam int ID_W         = 50;
  localparam int STATUS_W     = 2;

  // Used flags are stored as rows of ROW_BITS flags.
  localparam int ROW_BITS = 32;
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int ROWS     = (ID_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W    = ROW_W + BIT_W;
  localparam int PTR_W    = $clog2(ID_COUNT + 1);

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [ROW_W-1:0]    row_idx_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [PTR_W-1:0]    ptr_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_BAD_ID = 2'd2;

  // Position of the lowest clear bit; zero when there is none.
  function automatic logic [BIT_W-1:0] first_zero(row_t r);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!r[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[design/afa_if.sv]
// ----------------------------------------------------------------------------
// ASID allocator channels
// Valid/ready request and response channels of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface afa_req_if import afa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [ID_W-1:0] id_word;

  modport source (output valid, cmd, id_word, input ready);
  modport sink   (input valid, cmd, id_word, output ready);
endinterface

interface afa_rsp_if import afa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] id_out;
  status_t         status;

  modport source (output valid, id_out, status, input ready);
  modport sink   (input valid, id_out, status, output ready);
endinterface

[design/asid_first_free_allocator_unit.sv]
// ----------------------------------------------------------------------------
// ASID first-free allocator
// Hands out the lowest free address-space identifier on an allocate command
// and takes identifiers back on a free command; one response per request.
// The used flags live in a 32-row memory of 32 flags each, with one valid bit
// per row so every identifier reads as free after reset without a clearing
// pass. A free goes from acceptance through the modify state to the response
// register, and the next request is taken once the block is back in idle. An
// allocate goes through the modify state and then the scan state for each
// further row of flags the upward search for the next free identifier has to
// read; the single read port of the flag memory lets the search read one row
// at a time. An allocate on a full table and a free of an out-of-range
// identifier go straight to the response register. A new request is
// taken while an earlier response still waits in the output register; a
// second finished response then holds the block until the first is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asid_first_free_allocator_unit import afa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  afa_req_if.sink    req,
  afa_rsp_if.source  rsp
);

  `include "asid_first_free_allocator_unit_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]      state;
  logic            cmd_q;
  ptr_t            tgt;
  ptr_t            lowest_free;
  row_idx_t        scan_row;
  logic [ID_W-1:0] res_id;
  status_t         res_status;
  logic            out_valid;
  logic [ID_W-1:0] out_id;
  status_t         out_status;

  // Flag memory
  row_t            mem [ROWS];
  row_t            mem_q;
  logic            vld_q;
  logic [ROWS-1:0] row_valid;
  logic            rd_en;
  row_idx_t        rd_addr;
  logic            mem_we;

  row_t            row_q;
  row_t            row_mod;
  row_t            bit_mask;
  logic [BIT_W-1:0] tgt_bit;
  row_idx_t        cur_row;
  row_t            search;
  logic            any_zero;
  idx_t            found_idx;
  logic            found_in_range;
  ptr_t            found_ptr;
  logic            last_row;
  logic [ID_W-1:0] entry_word;
  logic            bad_id;
  logic            full;
  ptr_t            req_tgt;
  logic            req_reject;

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.id_out = out_id;
  assign rsp.status = out_status;

  assign entry_word = req.id_word >> TOTAL_SHIFT;
  assign bad_id     = (entry_word >= ID_W'(ID_COUNT));
  assign full       = (lowest_free == PTR_W'(ID_COUNT));
  assign req_tgt    = (req.cmd == CMD_FREE) ? PTR_W'(entry_word) : lowest_free;
  assign req_reject = (req.cmd == CMD_ALLOC) ? full : bad_id;

  // Row under modification or search; a row never written reads as all free.
  assign cur_row  = (state == S_MOD) ? ROW_W'(tgt >> BIT_W) : scan_row;
  assign row_q    = vld_q ? mem_q : '0;
  assign tgt_bit  = tgt[BIT_W-1:0];
  assign bit_mask = row_t'(1) << tgt_bit;
  assign row_mod  = (cmd_q == CMD_FREE) ? (row_q & ~bit_mask) : (row_q | bit_mask);

  // Every flag below the pointer is set, so the lowest clear flag is the answer.
  assign search         = (state == S_MOD) ? ~row_mod : ~row_q;
  assign any_zero       = |search;
  assign found_idx      = {cur_row, first_zero(~search)};
  assign found_in_range = ({1'b0, found_idx} < (IDX_W + 1)'(ID_COUNT));
  assign found_ptr      = found_in_range ? PTR_W'(found_idx) : PTR_W'(ID_COUNT);
  assign last_row       = (cur_row == ROW_W'(ROWS - 1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_row + ROW_W'(1);
    mem_we  = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid && !req_reject) begin
          rd_en   = 1'b1;
          rd_addr = ROW_W'(req_tgt >> BIT_W);
        end
      end
      S_MOD: begin
        mem_we = 1'b1;
        if (cmd_q == CMD_ALLOC && !any_zero && !last_row) begin
          rd_en = 1'b1;
        end
      end
      S_SCAN: begin
        if (!any_zero && !last_row) begin
          rd_en = 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_row] <= row_mod;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[cur_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lowest_free <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.cmd;
            tgt   <= req_tgt;
            if (req_reject) begin
              res_id     <= '0;
              res_status <= (req.cmd == CMD_ALLOC) ? ST_FULL : ST_BAD_ID;
              state      <= S_DONE;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          res_status <= ST_OK;
          if (cmd_q == CMD_FREE) begin
            res_id <= '0;
            if (tgt < lowest_free) begin
              lowest_free <= tgt;
            end
            state <= S_DONE;
          end else begin
            res_id <= ID_W'(tgt) << TOTAL_SHIFT;
            if (any_zero) begin
              lowest_free <= found_ptr;
              state       <= S_DONE;
            end else if (last_row) begin
              lowest_free <= PTR_W'(ID_COUNT);
              state       <= S_DONE;
            end else begin
              scan_row <= cur_row + ROW_W'(1);
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // advance one row a cycle until a clear flag or the table end
          if (any_zero) begin
            lowest_free <= found_ptr;
            state       <= S_DONE;
          end else if (last_row) begin
            lowest_free <= PTR_W'(ID_COUNT);
            state       <= S_DONE;
          end else begin
            scan_row <= cur_row + ROW_W'(1);
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_id     <= res_id;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `AFA_ASSERT_IMP(a_ptr_range, 1'b1, lowest_free <= PTR_W'(ID_COUNT))
  `AFA_ASSERT_IMP(a_alloc_free_flag, (state == S_MOD) && (cmd_q == CMD_ALLOC), !row_q[tgt_bit])
  `AFA_ASSERT_IMP(a_full_status, (state == S_DONE) && (res_status == ST_FULL), full)
  `AFA_ASSERT_NXT(a_free_done, (state == S_MOD) && (cmd_q == CMD_FREE), (state == S_DONE) && (res_status == ST_OK))

endmodule

[tb/sv/tb_asid_first_free_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ASID first-free allocator
// Runs a directed table of allocate and free transactions, then a random mix,
// then fills the whole table and runs past full. A local copy of the used
// flags and lowest-free pointer predicts the responses the table leaves open.
// ----------------------------------------------------------------------------

module tb_asid_first_free_allocator_unit import afa_pkg::*;;

  localparam int N_DIR       = 20;
  localparam int N_RANDOM    = 200;
  localparam int N_REFILL    = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 40;
  localparam int DRAIN_WAIT  = 40;
  localparam int IDLE_LIMIT  = 3000;

  localparam logic [ID_W-1:0] ALL_ONES = '1;
  localparam logic [ID_W-1:0] LOW_BITS = (ID_W'(1) << TOTAL_SHIFT) - 1;
  localparam logic [ID_W-1:0] ALT_A    = {25{2'b01}} & LOW_BITS;
  localparam logic [ID_W-1:0] ALT_B    = {25{2'b10}} & LOW_BITS;

  typedef struct packed {
    logic [ID_W-1:0] id_out;
    status_t         status;
  } asid_rsp_t;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] word;
    bit              typed;
    logic [ID_W-1:0] id_out;
    status_t         status;
  } dir_row_t;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} rdy_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  afa_req_if req_if ();
  afa_rsp_if rsp_if ();

  asid_first_free_allocator_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #2 clk = ~clk;

  // Local copy of the allocator state
  bit        id_used [ID_COUNT];
  int        next_free = 0;
  int        top_id = 0;
  asid_rsp_t asid_results_q [$];

  int        mismatch_count = 0;
  int        rsp_count = 0;
  int        burst_left = 0;
  dir_row_t  dir_rows [N_DIR];

  function automatic logic [ID_W-1:0] asid_word(int id);
    return ID_W'(id) << TOTAL_SHIFT;
  endfunction

  function automatic logic [ID_W-1:0] random_word();
    return ID_W'({$urandom(), $urandom()});
  endfunction

  // The identifier field spans bits 49:40, so at this table size every free
  // lands inside the table and bad_id is never produced.
  function automatic asid_rsp_t apply_asid_cmd(logic c, logic [ID_W-1:0] w);
    asid_rsp_t       r;
    logic [ID_W-1:0] wide;
    int              entry;
    r.id_out = '0;
    r.status = ST_OK;
    if (c == CMD_ALLOC) begin
      if (next_free < ID_COUNT) begin
        r.id_out = asid_word(next_free);
        id_used[next_free] = 1'b1;
        if (next_free > top_id) begin
          top_id = next_free;
        end
        do begin
          next_free++;
        end while (next_free < ID_COUNT && id_used[next_free]);
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      wide = w >> TOTAL_SHIFT;
      if (wide >= ID_COUNT) begin
        r.status = ST_BAD_ID;
      end else begin
        entry = int'(wide);
        id_used[entry] = 1'b0;
        if (entry < next_free) begin
          next_free = entry;
        end
      end
    end
    return r;
  endfunction

  // Offer one transaction in bursts with gaps; record the response it must get.
  task automatic send_req(input logic c, input logic [ID_W-1:0] w, input bit typed,
                          input asid_rsp_t typed_rsp);
    int        gap;
    asid_rsp_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.cmd     <= c;
    req_if.id_word <= w;
    do @(posedge clk); while (!req_if.ready);
    predicted = apply_asid_cmd(c, w);
    asid_results_q.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic send_random_free(input int hi);
    logic [ID_W-1:0] low;
    low = $urandom_range(0, 1) ? (random_word() & LOW_BITS) : '0;
    send_req(CMD_FREE, asid_word($urandom_range(0, hi)) | low, 1'b0, '0);
  endtask

  task automatic send_random_alloc();
    send_req(CMD_ALLOC, $urandom_range(0, 1) ? random_word() : '0, 1'b0, '0);
  endtask

  initial begin : stimulus
    dir_rows = '{
      '{CMD_ALLOC, ALL_ONES,                 1'b1, '0,           ST_OK},
      '{CMD_ALLOC, '0,                       1'b1, asid_word(1), ST_OK},
      '{CMD_ALLOC, '0,                       1'b1, asid_word(2), ST_OK},
      '{CMD_FREE,  asid_word(1) | LOW_BITS,  1'b1, '0,           ST_OK},
      '{CMD_ALLOC, '0,                       1'b1, asid_word(1), ST_OK},
      '{CMD_ALLOC, LOW_BITS,                 1'b1, asid_word(3), ST_OK},
      '{CMD_FREE,  ALL_ONES,                 1'b1, '0,           ST_OK},
      '{CMD_FREE,  asid_word(0),             1'b1, '0,           ST_OK},
      '{CMD_FREE,  asid_word(0),             1'b1, '0,           ST_OK},
      '{CMD_ALLOC, '0,                       1'b1, '0,           ST_OK},
      '{CMD_FREE,  asid_word(2),             1'b1, '0,           ST_OK},
      '{CMD_ALLOC, ALL_ONES,                 1'b1, asid_word(2), ST_OK},
      '{CMD_ALLOC, '0,                       1'b1, asid_word(4), ST_OK},
      '{CMD_FREE,  asid_word(31) | ALT_A,    1'b0, '0,           ST_OK},
      '{CMD_FREE,  asid_word(32) | ALT_B,    1'b0, '0,           ST_OK},
      '{CMD_ALLOC, ALT_B,                    1'b0, '0,           ST_OK},
      '{CMD_FREE,  asid_word(1022) | LOW_BITS, 1'b0, '0,         ST_OK},
      '{CMD_FREE,  asid_word(4),             1'b0, '0,           ST_OK},
      '{CMD_ALLOC, ALT_A,                    1'b0, '0,           ST_OK},
      '{CMD_ALLOC, '0,                       1'b0, '0,           ST_OK}
    };
    req_if.valid   <= 1'b0;
    req_if.cmd     <= CMD_ALLOC;
    req_if.id_word <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].cmd, dir_rows[i].word, dir_rows[i].typed,
               '{id_out: dir_rows[i].id_out, status: dir_rows[i].status});
    end

    // Lean toward allocation so the table grows; free mostly within the used range.
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 70) begin
        send_random_alloc();
      end else begin
        send_random_free(($urandom_range(0, 9) < 7) ? top_id : ID_COUNT - 1);
      end
    end

    // Fill the table, then run allocations against a full table.
    while (next_free < ID_COUNT) begin
      send_random_alloc();
    end
    repeat (4) send_random_alloc();

    for (int i = 0; i < N_REFILL; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_random_alloc();
      end else begin
        send_random_free(ID_COUNT - 1);
      end
    end

    req_if.valid <= 1'b0;
    while (asid_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_asid_first_free_allocator_unit: PASS");
    end else begin
      $display("tb_asid_first_free_allocator_unit: FAIL");
    end
    $finish;
  end

  // Response side: changing ready patterns plus one long hold-off.
  initial begin : rsp_ready_drive
    rdy_mode_e mode;
    int        mode_left;
    int        hold_left;
    int        phase;
    bit        held_off;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    held_off  = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!held_off && rsp_count >= HOLD_AFTER) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rdy_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          RDY_ALWAYS: begin
            rsp_if.ready <= 1'b1;
          end
          RDY_MOSTLY: begin
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
          end
          RDY_SPARSE: begin
            rsp_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            rsp_if.ready <= (phase % 3 != 2);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    asid_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      rsp_count++;
      if (asid_results_q.size() == 0) begin
        $display("%0t: response with no transaction pending: id_out=%h status=%0d",
                 $time, rsp_if.id_out, rsp_if.status);
        mismatch_count++;
      end else begin
        want = asid_results_q.pop_front();
        if (rsp_if.id_out !== want.id_out) begin
          $display("%0t: id_out mismatch: expected %h actual %h",
                   $time, want.id_out, rsp_if.id_out);
          mismatch_count++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp_if.status);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run when no transaction moves on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_asid_first_free_allocator_unit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+design
design/afa_pkg.sv
design/afa_if.sv
design/asid_first_free_allocator_unit.sv
tb/sv/tb_asid_first_free_allocator_unit.sv
